/* rtl/toma_pkg.sv */
// Shared types and constants of the three-axis offset moving average core.
`timescale 1ns / 1ps

package toma_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 24;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_OFFSET_Z    = 3'd2,
    REG_Z_LOWEST    = 3'd3,
    REG_Z_HIGHEST   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] x_ofs;
    logic signed [SampleW-1:0] y_ofs;
    logic signed [SampleW-1:0] z_ofs;
    logic signed [SampleW-1:0] z_lowest;
    logic signed [SampleW-1:0] z_highest;
  } cfg_t;

endpackage

/* rtl/toma_cfg.sv */
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module toma_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [toma_pkg::AddrW-1:0] paddr,
  input  logic [toma_pkg::DataW-1:0] pwdata,
  output logic [toma_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output toma_pkg::cfg_t             cfg_o
);
  import toma_pkg::*;

  cfg_t        cfg_q;
  cfg_t        cfg_d;
  logic        wr_en;
  logic [2:0]  idx;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_OFFSET_X:  cfg_d.x_ofs     = pwdata[SampleW-1:0];
        REG_OFFSET_Y:  cfg_d.y_ofs     = pwdata[SampleW-1:0];
        REG_OFFSET_Z:  cfg_d.z_ofs     = pwdata[SampleW-1:0];
        REG_Z_LOWEST:  cfg_d.z_lowest  = pwdata[SampleW-1:0];
        REG_Z_HIGHEST: cfg_d.z_highest = pwdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFSET_X:  prdata = {{(DataW-SampleW){1'b0}}, cfg_q.x_ofs};
      REG_OFFSET_Y:  prdata = {{(DataW-SampleW){1'b0}}, cfg_q.y_ofs};
      REG_OFFSET_Z:  prdata = {{(DataW-SampleW){1'b0}}, cfg_q.z_ofs};
      REG_Z_LOWEST:  prdata = {{(DataW-SampleW){1'b0}}, cfg_q.z_lowest};
      REG_Z_HIGHEST: prdata = {{(DataW-SampleW){1'b0}}, cfg_q.z_highest};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_ofs     <= '0;
      cfg_q.y_ofs     <= '0;
      cfg_q.z_ofs     <= '0;
      cfg_q.z_lowest  <= 16'sh8000;
      cfg_q.z_highest <= 16'sh7fff;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/toma_lane.sv */
// One axis lane: offset correction, ring buffer, running sum and division by the window.
`timescale 1ns / 1ps

module toma_lane #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic signed [toma_pkg::SampleW-1:0] sample_i,
  input  logic signed [toma_pkg::SampleW-1:0] offset_i,
  output logic signed [toma_pkg::SampleW-1:0] average_o
);
  import toma_pkg::*;

  localparam int unsigned SlotW   = $clog2(WINDOW);
  localparam int unsigned ShiftW  = SumW - 1 + $clog2(WINDOW);
  localparam int unsigned RecipW  = SumW;
  localparam int unsigned ProdW   = SumW - 1 + RecipW;
  localparam longint unsigned Recip = ((64'd1 << ShiftW) + WINDOW - 1) / WINDOW;
  localparam logic [RecipW-1:0] RecipC = RecipW'(Recip);

  logic [SampleW-1:0] ring_mem [WINDOW];
  logic [SampleW-1:0] rd_q;
  logic               rd_vld_q;
  logic [WINDOW-1:0]  vld_q;
  logic [SlotW-1:0]   slot_q;
  logic [SlotW-1:0]   slot_d;
  logic [SlotW-1:0]   slot_next;
  logic [SlotW-1:0]   rd_addr;
  logic [SumW-1:0]    sum_q;
  logic [SumW-1:0]    sum_d;
  logic [SampleW:0]   diff;
  logic [SampleW-1:0] corr;
  logic [SampleW-1:0] old;
  logic [SumW-1:0]    neg_sum;
  logic [SumW-2:0]    mag;
  logic [ProdW-1:0]   prod;
  logic [SampleW:0]   quo;
  logic [SampleW:0]   quo_s;

  assign diff = {sample_i[SampleW-1], sample_i} - {offset_i[SampleW-1], offset_i};
  always_comb begin
    if (diff[SampleW] != diff[SampleW-1]) begin
      corr = diff[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      corr = diff[SampleW-1:0];
    end
  end

  assign old       = rd_vld_q ? rd_q : '0;
  assign slot_next = (slot_q == SlotW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
  assign slot_d    = accept_i ? slot_next : slot_q;
  assign rd_addr   = slot_d;
  assign sum_d     = accept_i
                   ? sum_q + {{(SumW-SampleW){corr[SampleW-1]}}, corr}
                           - {{(SumW-SampleW){old[SampleW-1]}}, old}
                   : sum_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ring_mem[slot_q] <= corr;
    end
    rd_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      slot_q   <= '0;
      sum_q    <= '0;
    end else begin
      if (accept_i) begin
        vld_q[slot_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
      slot_q   <= slot_d;
      sum_q    <= sum_d;
    end
  end

  assign neg_sum = '0 - sum_q;
  assign mag     = sum_q[SumW-1] ? neg_sum[SumW-2:0] : sum_q[SumW-2:0];
  assign prod    = ProdW'(mag) * ProdW'(RecipC);
  assign quo     = prod[ShiftW +: SampleW+1];
  assign quo_s   = sum_q[SumW-1] ? ((SampleW+1)'(0) - quo) : quo;

  assign average_o = quo_s[SampleW-1:0];

endmodule

/* rtl/toma_merge.sv */
// Output stage that joins the lane averages and the fault flag into one result.
`timescale 1ns / 1ps

module toma_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fresh_i,
  input  logic signed [toma_pkg::SampleW-1:0] avg_x_i,
  input  logic signed [toma_pkg::SampleW-1:0] avg_y_i,
  input  logic signed [toma_pkg::SampleW-1:0] avg_z_i,
  input  toma_pkg::cfg_t                      cfg_i,
  input  logic                                out_stall_i,
  output logic                                take_o,
  output logic                                out_valid_o,
  output logic signed [toma_pkg::SampleW-1:0] average_x_o,
  output logic signed [toma_pkg::SampleW-1:0] average_y_o,
  output logic signed [toma_pkg::SampleW-1:0] average_z_o,
  output logic                                calibration_fault_o
);
  import toma_pkg::*;

  logic                      vld_q;
  logic signed [SampleW-1:0] ax_q;
  logic signed [SampleW-1:0] ay_q;
  logic signed [SampleW-1:0] az_q;
  logic                      fault_q;
  logic                      fault;
  logic                      room;

  assign room   = !vld_q || !out_stall_i;
  assign take_o = room;
  assign fault  = (cfg_i.z_ofs > cfg_i.z_highest) || (cfg_i.z_ofs < cfg_i.z_lowest);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (room) begin
      vld_q <= fresh_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room && fresh_i) begin
      ax_q    <= avg_x_i;
      ay_q    <= avg_y_i;
      az_q    <= avg_z_i;
      fault_q <= fault;
    end
  end

  assign out_valid_o         = vld_q;
  assign average_x_o         = ax_q;
  assign average_y_o         = ay_q;
  assign average_z_o         = az_q;
  assign calibration_fault_o = fault_q;

endmodule

/* rtl/three_axis_offset_moving_average_core.sv */
// Top level of the three-axis offset-corrected moving average core.
// Each input transaction carries one X, Y and Z sample. Each axis has its own
// lane that subtracts the calibration offset with saturation, replaces the
// oldest ring entry and updates a running sum; X and Y average over WINDOW_XY
// samples and Z over WINDOW_Z. One result transaction follows every input
// transaction, carrying the three averages and the calibration fault flag.
// Both channels use valid and stall; configuration is written over the APB
// port, which is always ready and should only be used while the core is idle.
// out_valid_o rises when the result moves from the lane sum register into the
// output register, and the core takes one transaction per cycle while the
// receiver does not stall: the lane sum register and the output register form
// a two-stage pipeline, and the reciprocal multiply of each lane sits between them.
// While the receiver stalls, a result waits in the output register and one more
// transaction can be taken into the sum stage; after that in_stall_o rises.
// Reset zeroes the ring valid flags, sums and slot pointers and loads the register
// defaults; empty ring entries count as zero, so the averages ramp up from zero.
`timescale 1ns / 1ps

module three_axis_offset_moving_average_core #(
  parameter int unsigned WINDOW_XY = 16,
  parameter int unsigned WINDOW_Z  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [toma_pkg::AddrW-1:0]          paddr,
  input  logic [toma_pkg::DataW-1:0]          pwdata,
  output logic [toma_pkg::DataW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [toma_pkg::SampleW-1:0] sample_x_i,
  input  logic signed [toma_pkg::SampleW-1:0] sample_y_i,
  input  logic signed [toma_pkg::SampleW-1:0] sample_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [toma_pkg::SampleW-1:0] average_x_o,
  output logic signed [toma_pkg::SampleW-1:0] average_y_o,
  output logic signed [toma_pkg::SampleW-1:0] average_z_o,
  output logic                                calibration_fault_o
);
  import toma_pkg::*;

  cfg_t                      cfg;
  logic                      fresh_q;
  logic                      fresh_d;
  logic                      take;
  logic                      accept;
  logic signed [SampleW-1:0] avg_x;
  logic signed [SampleW-1:0] avg_y;
  logic signed [SampleW-1:0] avg_z;

  assign in_stall_o = fresh_q && !take;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    priority if (accept) begin
      fresh_d = 1'b1;
    end else if (take) begin
      fresh_d = 1'b0;
    end else begin
      fresh_d = fresh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
    end
  end

  toma_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  toma_lane #(.WINDOW(WINDOW_XY)) u_lane_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_i  (sample_x_i),
    .offset_i  (cfg.x_ofs),
    .average_o (avg_x)
  );

  toma_lane #(.WINDOW(WINDOW_XY)) u_lane_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_i  (sample_y_i),
    .offset_i  (cfg.y_ofs),
    .average_o (avg_y)
  );

  toma_lane #(.WINDOW(WINDOW_Z)) u_lane_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_i  (sample_z_i),
    .offset_i  (cfg.z_ofs),
    .average_o (avg_z)
  );

  toma_merge u_merge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .fresh_i             (fresh_q),
    .avg_x_i             (avg_x),
    .avg_y_i             (avg_y),
    .avg_z_i             (avg_z),
    .cfg_i               (cfg),
    .out_stall_i         (out_stall_i),
    .take_o              (take),
    .out_valid_o         (out_valid_o),
    .average_x_o         (average_x_o),
    .average_y_o         (average_y_o),
    .average_z_o         (average_z_o),
    .calibration_fault_o (calibration_fault_o)
  );

endmodule
